// ===== hw/rtl/lprl_pkg.sv =====
// Shared types, constants and helpers for the longest-prefix route lookup.
package lprl_pkg;

  // Field widths of one item.
  localparam int ADDR_W    = 32;
  localparam int PFX_W     = 6;
  localparam int IDX_W     = 4;
  localparam int HOP_W     = 8;
  localparam int HOP_EXT_W = 16;

  // Slots that the entry_index field can reach.
  localparam int SLOT_LIMIT = 1 << IDX_W;

  // Defaults for the top-level parameters.
  localparam int DEF_ROUTE_ENTRIES = 16;
  localparam int DEF_NEXT_HOP_BITS = 8;

  // Longest legal prefix.
  localparam logic [PFX_W-1:0] MAX_PREFIX = PFX_W'(32);

  // Item action codes.
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // One item as it travels down the chain, with the best match found so far.
  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  entry_index;
    logic              entry_valid;
    logic [ADDR_W-1:0] route_network;
    logic [PFX_W-1:0]  route_prefix;
    logic [HOP_W-1:0]  route_next_hop;
    logic [ADDR_W-1:0] destination;
    logic              found;
    logic [IDX_W-1:0]  best_index;
    logic [PFX_W-1:0]  best_prefix;
    logic [HOP_W-1:0]  best_hop;
  } token_t;

  // Network mask for a prefix length; lengths of 32 and above give all ones.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] pfx);
    logic [ADDR_W-1:0] mask;
    if (pfx == '0) begin
      mask = '0;
    end else if (pfx >= MAX_PREFIX) begin
      mask = '1;
    end else begin
      mask = ~({ADDR_W{1'b1}} >> pfx);
    end
    return mask;
  endfunction

endpackage

// ===== hw/rtl/longest_prefix_route_lookup_core.sv =====
// Top level of the IPv4 longest-prefix route lookup: a chain of route slots.
//
// Usage: each item on the in_ channel is either a route write (in_action 0)
// or a destination lookup (in_action 1). Every item gives exactly one item
// on the out_ channel, in order. A write returns all zeros; a lookup returns
// hit, the slot index, the prefix length and the next hop of the longest
// covering route, lowest slot first among equal lengths, or all zeros.
// Each item passes through the registered stage of every slot, in order,
// before it reaches out_valid. Throughput: one item per cycle while
// out_stall does not freeze the chain, since items walk the chain in order
// and each slot is visited once per item. Reset clears every slot to
// invalid and empties the chain; items are taken once reset is released.
// When the receiver holds out_stall while out_valid is high, the whole
// chain freezes, the result holds and in_stall goes high in that cycle.
module longest_prefix_route_lookup_core #(
  parameter int ROUTE_ENTRIES = lprl_pkg::DEF_ROUTE_ENTRIES,
  parameter int NEXT_HOP_BITS = lprl_pkg::DEF_NEXT_HOP_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [lprl_pkg::IDX_W-1:0]    in_entry_index,
  input  logic                          in_entry_valid,
  input  logic [lprl_pkg::ADDR_W-1:0]   in_route_network,
  input  logic [lprl_pkg::PFX_W-1:0]    in_route_prefix,
  input  logic [lprl_pkg::HOP_W-1:0]    in_route_next_hop,
  input  logic [lprl_pkg::ADDR_W-1:0]   in_destination,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [lprl_pkg::IDX_W-1:0]    out_matched_index,
  output logic [lprl_pkg::PFX_W-1:0]    out_matched_prefix,
  output logic [lprl_pkg::HOP_W-1:0]    out_next_hop
);
  import lprl_pkg::*;

  logic   advance;
  logic   link_valid [ROUTE_ENTRIES+1];
  token_t link_tok   [ROUTE_ENTRIES+1];
  token_t head_tok;

  // The chain moves unless a finished item waits at the end.
  assign advance  = !(link_valid[ROUTE_ENTRIES] && out_stall);
  assign in_stall = !advance;

  // Incoming item enters the first slot with no match yet.
  always_comb begin
    head_tok                = '0;
    head_tok.action         = in_action;
    head_tok.entry_index    = in_entry_index;
    head_tok.entry_valid    = in_entry_valid;
    head_tok.route_network  = in_route_network;
    head_tok.route_prefix   = in_route_prefix;
    head_tok.route_next_hop = in_route_next_hop;
    head_tok.destination    = in_destination;
  end

  assign link_valid[0] = in_valid;
  assign link_tok[0]   = head_tok;

  // One cell per route slot.
  for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
    lprl_cell #(
      .CELL_IDX      (g),
      .NEXT_HOP_BITS (NEXT_HOP_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .up_valid (link_valid[g]),
      .up_tok   (link_tok[g]),
      .dn_valid (link_valid[g+1]),
      .dn_tok   (link_tok[g+1])
    );
  end

  // Result from the last stage; best fields stay zero unless a match was found.
  assign out_valid          = link_valid[ROUTE_ENTRIES];
  assign out_hit            = link_tok[ROUTE_ENTRIES].found;
  assign out_matched_index  = link_tok[ROUTE_ENTRIES].best_index;
  assign out_matched_prefix = link_tok[ROUTE_ENTRIES].best_prefix;
  assign out_next_hop       = link_tok[ROUTE_ENTRIES].best_hop;

endmodule

// ===== hw/rtl/lprl_cell.sv =====
// One route slot of the chain: holds an entry and passes each item to the next slot.
module lprl_cell #(
  parameter int CELL_IDX      = 0,
  parameter int NEXT_HOP_BITS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic            up_valid,
  input  lprl_pkg::token_t up_tok,
  output logic            dn_valid,
  output lprl_pkg::token_t dn_tok
);
  import lprl_pkg::*;

  localparam bit CELL_REACHABLE = (CELL_IDX < SLOT_LIMIT);

  // Stored entry.
  logic                     ent_valid_r, ent_valid_nxt;
  logic [ADDR_W-1:0]        ent_network_r, ent_network_nxt;
  logic [ADDR_W-1:0]        ent_mask_r, ent_mask_nxt;
  logic [PFX_W-1:0]         ent_prefix_r, ent_prefix_nxt;
  logic [NEXT_HOP_BITS-1:0] ent_hop_r, ent_hop_nxt;

  // Item stage toward the next cell.
  logic   dn_valid_r;
  token_t dn_tok_r, dn_tok_nxt;

  logic                 wr_sel;
  logic                 covers;
  logic                 better;
  logic [PFX_W-1:0]     pfx_sat;
  logic [ADDR_W-1:0]    wr_mask;
  logic [HOP_EXT_W-1:0] in_hop_ext;
  logic [HOP_EXT_W-1:0] ent_hop_ext;

  // A write item updates this slot only when its index names it.
  assign wr_sel = CELL_REACHABLE && advance && up_valid && (up_tok.action == ACT_WRITE)
                  && (up_tok.entry_index == IDX_W'(CELL_IDX));

  assign pfx_sat    = (up_tok.route_prefix > MAX_PREFIX) ? MAX_PREFIX : up_tok.route_prefix;
  assign wr_mask    = prefix_mask(pfx_sat);
  assign in_hop_ext = HOP_EXT_W'(up_tok.route_next_hop);

  // New entry contents; a removal clears every field.
  always_comb begin
    if (up_tok.entry_valid) begin
      ent_valid_nxt   = 1'b1;
      ent_prefix_nxt  = pfx_sat;
      ent_mask_nxt    = wr_mask;
      ent_network_nxt = up_tok.route_network & wr_mask;
      ent_hop_nxt     = in_hop_ext[NEXT_HOP_BITS-1:0];
    end else begin
      ent_valid_nxt   = 1'b0;
      ent_prefix_nxt  = '0;
      ent_mask_nxt    = '0;
      ent_network_nxt = '0;
      ent_hop_nxt     = '0;
    end
  end

  // Match test; a strictly longer prefix replaces, so lower slots win ties.
  assign covers      = ent_valid_r && ((up_tok.destination & ent_mask_r) == ent_network_r);
  assign better      = !up_tok.found || (ent_prefix_r > up_tok.best_prefix);
  assign ent_hop_ext = HOP_EXT_W'(ent_hop_r);

  always_comb begin
    dn_tok_nxt = up_tok;
    if ((up_tok.action == ACT_LOOKUP) && covers && better) begin
      dn_tok_nxt.found       = 1'b1;
      dn_tok_nxt.best_index  = IDX_W'(CELL_IDX);
      dn_tok_nxt.best_prefix = ent_prefix_r;
      dn_tok_nxt.best_hop    = ent_hop_ext[HOP_W-1:0];
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (wr_sel) begin
      ent_valid_r <= ent_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      ent_network_r <= ent_network_nxt;
      ent_mask_r    <= ent_mask_nxt;
      ent_prefix_r  <= ent_prefix_nxt;
      ent_hop_r     <= ent_hop_nxt;
    end
  end

  // Item stage; the whole chain moves together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_valid_r <= 1'b0;
    end else if (advance) begin
      dn_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dn_tok_r <= dn_tok_nxt;
    end
  end

  assign dn_valid = dn_valid_r;
  assign dn_tok   = dn_tok_r;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the longest-prefix route lookup core.
module testbench;
  import lprl_pkg::*;

  localparam int ROUTE_SLOTS  = DEF_ROUTE_ENTRIES;
  localparam int HOP_KEEP     = DEF_NEXT_HOP_BITS;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 500;

  // One item as the sender offers it.
  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  index;
    logic              entry_valid;
    logic [ADDR_W-1:0] network;
    logic [PFX_W-1:0]  prefix;
    logic [HOP_W-1:0]  hop;
    logic [ADDR_W-1:0] destination;
  } route_item_t;

  // One result item: what the lookup answers.
  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  index;
    logic [PFX_W-1:0]  prefix;
    logic [HOP_W-1:0]  hop;
  } route_answer_t;

  // Shadow copy of one slot of the route table.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] network;
    logic [PFX_W-1:0]  prefix;
    logic [HOP_W-1:0]  hop;
  } route_slot_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_action = ACT_WRITE;
  logic [IDX_W-1:0]    in_entry_index = '0;
  logic                in_entry_valid = 1'b0;
  logic [ADDR_W-1:0]   in_route_network = '0;
  logic [PFX_W-1:0]    in_route_prefix = '0;
  logic [HOP_W-1:0]    in_route_next_hop = '0;
  logic [ADDR_W-1:0]   in_destination = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic [IDX_W-1:0]    out_matched_index;
  logic [PFX_W-1:0]    out_matched_prefix;
  logic [HOP_W-1:0]    out_next_hop;

  route_slot_t   route_shadow [ROUTE_SLOTS];
  route_answer_t expected_answers [$];
  int unsigned   mismatches = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  logic          hold_start = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;

  longest_prefix_route_lookup_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_entry_index     (in_entry_index),
    .in_entry_valid     (in_entry_valid),
    .in_route_network   (in_route_network),
    .in_route_prefix    (in_route_prefix),
    .in_route_next_hop  (in_route_next_hop),
    .in_destination     (in_destination),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_matched_index  (out_matched_index),
    .out_matched_prefix (out_matched_prefix),
    .out_next_hop       (out_next_hop)
  );

  // Free-running clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Network mask for a prefix length: the top bits of a shifted window of ones.
  function automatic logic [ADDR_W-1:0] netmask_for(input logic [PFX_W-1:0] pfx);
    logic [2*ADDR_W-1:0] window;
    logic [PFX_W-1:0]    len;
    len    = (pfx > MAX_PREFIX) ? MAX_PREFIX : pfx;
    window = {{ADDR_W{1'b1}}, {ADDR_W{1'b0}}} >> len;
    return window[ADDR_W-1:0];
  endfunction

  // Applies one item to the shadow table and returns the answer it must give.
  function automatic route_answer_t apply_route_item(input route_item_t it);
    route_answer_t    ans;
    logic [PFX_W-1:0] len;
    ans = '0;
    if (it.action == ACT_WRITE) begin
      if (int'(it.index) < ROUTE_SLOTS) begin
        if (it.entry_valid) begin
          len = (it.prefix > MAX_PREFIX) ? MAX_PREFIX : it.prefix;
          route_shadow[it.index].valid   = 1'b1;
          route_shadow[it.index].prefix  = len;
          route_shadow[it.index].network = it.network & netmask_for(len);
          route_shadow[it.index].hop     = it.hop & HOP_W'((1 << HOP_KEEP) - 1);
        end else begin
          route_shadow[it.index] = '0;
        end
      end
    end else begin
      // Strictly longer prefixes replace the pick, so the lowest slot wins ties.
      for (int s = 0; s < ROUTE_SLOTS; s++) begin
        if (route_shadow[s].valid &&
            (it.destination & netmask_for(route_shadow[s].prefix)) ==
              route_shadow[s].network &&
            (!ans.hit || route_shadow[s].prefix > ans.prefix)) begin
          ans.hit    = 1'b1;
          ans.index  = IDX_W'(s);
          ans.prefix = route_shadow[s].prefix;
          ans.hop    = route_shadow[s].hop;
        end
      end
    end
    return ans;
  endfunction

  // Offers one item, holds it until accepted and records its answer.
  task automatic send_item(input route_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_action         <= it.action;
    in_entry_index    <= it.index;
    in_entry_valid    <= it.entry_valid;
    in_route_network  <= it.network;
    in_route_prefix   <= it.prefix;
    in_route_next_hop <= it.hop;
    in_destination    <= it.destination;
    in_valid          <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_answers.insert(expected_answers.size(), apply_route_item(it));
  endtask

  task automatic send_write(input logic [IDX_W-1:0] idx, input logic keep,
                            input logic [ADDR_W-1:0] net, input logic [PFX_W-1:0] pfx,
                            input logic [HOP_W-1:0] hop);
    route_item_t it;
    it = '{ACT_WRITE, idx, keep, net, pfx, hop, ADDR_W'($urandom)};
    send_item(it);
  endtask

  task automatic send_lookup(input logic [ADDR_W-1:0] dest);
    route_item_t it;
    it = '{ACT_LOOKUP, IDX_W'($urandom), 1'($urandom), ADDR_W'($urandom),
           PFX_W'($urandom), HOP_W'($urandom), dest};
    send_item(it);
  endtask

  // Builds a random item, mostly aimed at routes already in the table.
  function automatic route_item_t make_random_item();
    route_item_t it;
    route_slot_t aim;
    int unsigned roll;
    it.action      = ($urandom_range(99) < 30) ? ACT_WRITE : ACT_LOOKUP;
    it.index       = IDX_W'($urandom_range(ROUTE_SLOTS - 1));
    it.entry_valid = ($urandom_range(99) >= 15);
    it.network     = ADDR_W'($urandom);
    it.hop         = HOP_W'($urandom_range(255));
    it.destination = ADDR_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 3) begin
      it.prefix = '0;
    end else if (roll < 10) begin
      it.prefix = PFX_W'($urandom_range(63, 33));
    end else begin
      it.prefix = PFX_W'($urandom_range(32, 1));
    end
    aim = route_shadow[$urandom_range(ROUTE_SLOTS - 1)];
    if (aim.valid) begin
      // Nested and duplicate routes exercise the longest-match and tie rules.
      if (it.action == ACT_WRITE && $urandom_range(99) < 40) begin
        it.network = aim.network | (ADDR_W'($urandom) & ~netmask_for(aim.prefix));
        if ($urandom_range(99) < 25) it.prefix = aim.prefix;
      end
      // Lookups mostly land inside a stored route, some just outside it.
      if (it.action == ACT_LOOKUP && $urandom_range(99) < 75) begin
        it.destination = aim.network | (ADDR_W'($urandom) & ~netmask_for(aim.prefix));
        if ($urandom_range(99) < 15) it.destination ^= ADDR_W'(1) << $urandom_range(31);
      end
    end
    return it;
  endfunction

  // Stops offering items until every answer has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // Empty table, default route, host-bit masking, saturation, ties and removal.
  task automatic test_directed_cases();
    send_idle_pct = 20;
    recv_stall_pct <= 62;
    send_lookup(32'h0A01_0203);
    send_write(4'd0, 1'b1, 32'h1234_5678, 6'd0, 8'hAA);
    send_write(4'd15, 1'b1, 32'hFFFF_FFFF, 6'd32, 8'hFF);
    send_write(4'd3, 1'b1, 32'h0A0B_0C0D, 6'd8, 8'h11);
    send_write(4'd5, 1'b1, 32'h0A00_0000, 6'd8, 8'h22);
    send_write(4'd7, 1'b1, 32'h0A0B_0001, 6'd63, 8'h33);
    send_write(4'd9, 1'b1, 32'hC0A8_0155, 6'd33, 8'h00);
    send_write(4'd8, 1'b1, 32'hFFFF_FFFF, 6'd1, 8'h80);
    send_lookup(32'h0A12_3456);
    send_lookup(32'h0A0B_0001);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h0000_0000);
    send_lookup(32'hC0A8_0155);
    send_lookup(32'hC0A8_0154);
    send_lookup(32'h8000_0000);
    send_write(4'd3, 1'b0, ADDR_W'($urandom), PFX_W'($urandom), HOP_W'($urandom));
    send_lookup(32'h0A12_3456);
    send_write(4'd0, 1'b0, ADDR_W'($urandom), PFX_W'($urandom), HOP_W'($urandom));
    send_write(4'd8, 1'b0, ADDR_W'($urandom), PFX_W'($urandom), HOP_W'($urandom));
    send_lookup(32'h0102_0304);
    wait_for_drain();
  endtask

  // Random writes and lookups at the given idle and stall rates.
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (count) send_item(make_random_item());
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_receiver_hold();
    send_idle_pct = 0;
    hold_start <= 1'b1;
    repeat (60) send_item(make_random_item());
  endtask

  // The sender goes quiet until the pipeline is empty, then resumes.
  task automatic test_sender_pause();
    send_idle_pct = 0;
    repeat (30) send_item(make_random_item());
    wait_for_drain();
    repeat (30) send_item(make_random_item());
  endtask

  // Result-side stall, with an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_start) begin
      hold_start <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [ADDR_W-1:0] want,
                                      input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Compares each accepted result with the oldest outstanding answer.
  always @(posedge clk) begin : check_result
    route_answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual hit %0b index %0d",
                 $time, out_hit, out_matched_index);
      end else begin
        want = expected_answers.pop_front();
        check_field("hit", ADDR_W'(want.hit), ADDR_W'(out_hit));
        check_field("matched_index", ADDR_W'(want.index), ADDR_W'(out_matched_index));
        check_field("matched_prefix", ADDR_W'(want.prefix), ADDR_W'(out_matched_prefix));
        check_field("next_hop", ADDR_W'(want.hop), ADDR_W'(out_next_hop));
      end
    end
  end

  // Ends the run when neither channel moves an item for too long.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("longest_prefix_route_lookup_core regression: fail");
    $finish;
  end

  // Test sequence.
  initial begin
    for (int s = 0; s < ROUTE_SLOTS; s++) route_shadow[s] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic(RANDOM_ITEMS, 20, 62);
    test_receiver_hold();
    test_random_traffic(RANDOM_ITEMS, 62, 20);
    test_sender_pause();
    test_random_traffic(RANDOM_ITEMS, 0, 0);
    wait_for_drain();
    repeat (ROUTE_SLOTS + 8) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("longest_prefix_route_lookup_core regression: pass");
    end else begin
      $display("longest_prefix_route_lookup_core regression: fail");
    end
    $finish;
  end

endmodule
